### hdl/button_click_hold_classifier_assert.svh
// Assertion macros used by the button classifier back end.
`ifndef BUTTON_CLICK_HOLD_CLASSIFIER_ASSERT_SVH
`define BUTTON_CLICK_HOLD_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define BCHC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bchc: same-cycle check failed");

// Next-cycle implication, clocked on clk, off during rst.
`define BCHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bchc: next-cycle check failed");

`endif

### hdl/bchc_pkg.sv
// Types and constants of the button click and hold classifier.
package bchc_pkg;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_DEB_PRESS1,
    PH_HELD1,
    PH_DEB_REL1,
    PH_GAP,
    PH_DEB_PRESS2,
    PH_HELD2,
    PH_DEB_REL2,
    PH_END
  } phase_t;

  localparam logic [2:0] KIND_HOLD1  = 3'd0;
  localparam logic [2:0] KIND_HOLD2  = 3'd1;
  localparam logic [2:0] KIND_HOLD3  = 3'd2;
  localparam logic [2:0] KIND_HOLD4  = 3'd3;
  localparam logic [2:0] KIND_SINGLE = 3'd4;
  localparam logic [2:0] KIND_DOUBLE = 3'd5;
  localparam logic [2:0] KIND_TRIPLE = 3'd6;
  localparam logic [2:0] KIND_QUAD   = 3'd7;

  localparam logic [2:0] REG_DEBOUNCE = 3'd0;
  localparam logic [2:0] REG_REPEAT   = 3'd1;
  localparam logic [2:0] REG_GAP      = 3'd2;
  localparam logic [2:0] REG_TIER1    = 3'd3;
  localparam logic [2:0] REG_TIER2    = 3'd4;
  localparam logic [2:0] REG_TIER3    = 3'd5;
  localparam logic [2:0] REG_TIER4    = 3'd6;
  localparam logic [2:0] REG_BUTTON   = 3'd7;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] repeat_interval_ms;
    logic [15:0] gap_timeout_ms;
    logic [23:0] hold_tier1_ms;
    logic [23:0] hold_tier2_ms;
    logic [23:0] hold_tier3_ms;
    logic [23:0] hold_tier4_ms;
    logic [3:0]  button_id;
  } cfg_t;

  // One queued pass: the event it reports, once or twice.
  typedef struct packed {
    logic [2:0] kind;
    logic       fin;
    logic [3:0] button;
    logic       two;
  } rec_t;

endpackage

### hdl/bchc_in_if.sv
// Input channel: one polling pass per item.
interface bchc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        pin_pressed;
  logic        rise_seen;
  logic        fall_seen;

  modport source (output valid, now_ms, pin_pressed, rise_seen, fall_seen, input ready);
  modport sink   (input valid, now_ms, pin_pressed, rise_seen, fall_seen, output ready);
endinterface

### hdl/bchc_out_if.sv
// Output channel: one button event per item.
interface bchc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic       is_final;
  logic [3:0] event_button;
  logic       last;

  modport source (output valid, event_kind, is_final, event_button, last, input ready);
  modport sink   (input valid, event_kind, is_final, event_button, last, output ready);
endinterface

### hdl/bchc_fifo.sv
// Short queue of pass records between the classifier and the event sender.
module bchc_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bchc_pkg::rec_t  wr_data,
  input  logic            pop,
  output bchc_pkg::rec_t  rd_data,
  output logic            full,
  output logic            empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bchc_pkg::rec_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

### hdl/bchc_front.sv
// Front end: accept polling passes, run the click/hold machine, queue events.
module bchc_front (
  input  logic           clk,
  input  logic           rst,
  bchc_in_if.sink        in_ch,
  input  bchc_pkg::cfg_t cfg,
  input  logic           q_full,
  output logic           push,
  output bchc_pkg::rec_t rec
);
  bchc_pkg::phase_t phase, phase_next;
  logic        rise_flag, rise_flag_next;
  logic        fall_flag, fall_flag_next;
  logic [31:0] phase_start, phase_start_next;
  logic [31:0] press_start, press_start_next;
  logic [31:0] last_report, last_report_next;
  logic [15:0] click_count, click_count_next;

  logic [31:0] dur, el_phase, el_rep;
  logic        rf, ff, released;
  logic [15:0] cnt_sel;
  logic        hit;
  logic [2:0]  kind;
  logic [1:0]  n_rep;
  logic        fin;
  logic        accept;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !q_full;

  assign dur      = in_ch.now_ms - press_start;
  assign el_phase = in_ch.now_ms - phase_start;
  assign el_rep   = in_ch.now_ms - last_report;
  assign rf       = rise_flag | in_ch.rise_seen;
  assign ff       = fall_flag | in_ch.fall_seen;
  assign released = ff || !in_ch.pin_pressed;

  // Report classification shared by every reporting phase.
  always_comb begin
    hit  = 1'b0;
    kind = bchc_pkg::KIND_SINGLE;
    if (cnt_sel == 16'd0 || cnt_sel == 16'd1) begin
      if (dur >= {8'd0, cfg.hold_tier1_ms} && dur < {8'd0, cfg.hold_tier2_ms}) begin
        hit = 1'b1; kind = bchc_pkg::KIND_HOLD1;
      end else if (dur >= {8'd0, cfg.hold_tier2_ms} && dur < {8'd0, cfg.hold_tier3_ms}) begin
        hit = 1'b1; kind = bchc_pkg::KIND_HOLD2;
      end else if (dur >= {8'd0, cfg.hold_tier3_ms} && dur < {8'd0, cfg.hold_tier4_ms}) begin
        hit = 1'b1; kind = bchc_pkg::KIND_HOLD3;
      end else if (dur >= {8'd0, cfg.hold_tier4_ms}) begin
        hit = 1'b1; kind = bchc_pkg::KIND_HOLD4;
      end else if (cnt_sel == 16'd1) begin
        hit = 1'b1; kind = bchc_pkg::KIND_SINGLE;
      end
    end else if (cnt_sel == 16'd2) begin
      hit = 1'b1; kind = bchc_pkg::KIND_DOUBLE;
    end else if (cnt_sel == 16'd3) begin
      hit = 1'b1; kind = bchc_pkg::KIND_TRIPLE;
    end else if (cnt_sel == 16'd4) begin
      hit = 1'b1; kind = bchc_pkg::KIND_QUAD;
    end
  end

  always_comb begin
    phase_next       = phase;
    rise_flag_next   = rf;
    fall_flag_next   = ff;
    phase_start_next = phase_start;
    press_start_next = press_start;
    last_report_next = last_report;
    click_count_next = click_count;
    cnt_sel          = click_count;
    n_rep            = 2'd0;
    fin              = 1'b0;
    case (phase)
      bchc_pkg::PH_IDLE: begin
        if (rf) begin
          rise_flag_next   = 1'b0;
          fall_flag_next   = 1'b0;
          phase_start_next = in_ch.now_ms;
          press_start_next = in_ch.now_ms;
          last_report_next = in_ch.now_ms;
          phase_next       = bchc_pkg::PH_DEB_PRESS1;
        end
      end
      bchc_pkg::PH_DEB_PRESS1: begin
        if (dur >= {16'd0, cfg.debounce_ms}) begin
          phase_next = in_ch.pin_pressed ? bchc_pkg::PH_HELD1 : bchc_pkg::PH_END;
        end
      end
      bchc_pkg::PH_HELD1: begin
        // release and repeat reports share the new count, so they match
        cnt_sel = click_count + {15'd0, released};
        if (released) begin
          fall_flag_next   = 1'b0;
          click_count_next = cnt_sel;
          phase_start_next = in_ch.now_ms;
          phase_next       = bchc_pkg::PH_DEB_REL1;
        end
        if (el_rep >= {16'd0, cfg.repeat_interval_ms}) begin
          last_report_next = in_ch.now_ms;
        end
        n_rep = {1'b0, released} + {1'b0, el_rep >= {16'd0, cfg.repeat_interval_ms}};
      end
      bchc_pkg::PH_DEB_REL1, bchc_pkg::PH_DEB_REL2: begin
        if (el_phase >= {16'd0, cfg.debounce_ms}) begin
          phase_next = bchc_pkg::PH_GAP;
        end
      end
      bchc_pkg::PH_GAP: begin
        if (rf) begin
          rise_flag_next   = 1'b0;
          phase_start_next = in_ch.now_ms;
          phase_next       = bchc_pkg::PH_DEB_PRESS2;
        end else if (el_phase >= {16'd0, cfg.gap_timeout_ms}) begin
          n_rep      = 2'd1;
          fin        = 1'b1;
          phase_next = bchc_pkg::PH_END;
        end
      end
      bchc_pkg::PH_DEB_PRESS2: begin
        if (el_phase >= {16'd0, cfg.debounce_ms}) begin
          phase_next = in_ch.pin_pressed ? bchc_pkg::PH_HELD2 : bchc_pkg::PH_GAP;
        end
      end
      bchc_pkg::PH_HELD2: begin
        cnt_sel = click_count + 16'd1;
        if (released) begin
          fall_flag_next   = 1'b0;
          click_count_next = cnt_sel;
          phase_start_next = in_ch.now_ms;
          phase_next       = bchc_pkg::PH_DEB_REL2;
          n_rep            = 2'd1;
        end
      end
      default: begin
        click_count_next = '0;
        phase_next       = bchc_pkg::PH_IDLE;
      end
    endcase
  end

  assign push       = accept && hit && (n_rep != 2'd0);
  assign rec.kind   = kind;
  assign rec.fin    = fin;
  assign rec.button = cfg.button_id;
  assign rec.two    = (n_rep == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= bchc_pkg::PH_IDLE;
      rise_flag   <= 1'b0;
      fall_flag   <= 1'b0;
      phase_start <= '0;
      press_start <= '0;
      last_report <= '0;
      click_count <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      rise_flag   <= rise_flag_next;
      fall_flag   <= fall_flag_next;
      phase_start <= phase_start_next;
      press_start <= press_start_next;
      last_report <= last_report_next;
      click_count <= click_count_next;
    end
  end
endmodule

### hdl/bchc_back.sv
// Back end: pop pass records and send their events with the last marker.
`include "button_click_hold_classifier_assert.svh"

module bchc_back (
  input  logic           clk,
  input  logic           rst,
  input  bchc_pkg::rec_t rd_data,
  input  logic           q_empty,
  output logic           pop,
  bchc_out_if.source     out_ch
);
  logic       ov;
  logic       sec;
  logic [2:0] kind_q;
  logic       fin_q;
  logic [3:0] button_q;
  logic       last_q;
  logic       advance;

  assign advance = !ov || out_ch.ready;
  assign pop     = advance && !(ov && sec) && !q_empty;

  assign out_ch.valid        = ov;
  assign out_ch.event_kind   = kind_q;
  assign out_ch.is_final     = fin_q;
  assign out_ch.event_button = button_q;
  assign out_ch.last         = last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov  <= 1'b0;
      sec <= 1'b0;
    end else if (advance) begin
      if (ov && sec) begin
        sec <= 1'b0;
      end else if (!q_empty) begin
        ov  <= 1'b1;
        sec <= rd_data.two;
      end else begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (ov && sec) begin
        last_q <= 1'b1;
      end else if (!q_empty) begin
        kind_q   <= rd_data.kind;
        fin_q    <= rd_data.fin;
        button_q <= rd_data.button;
        last_q   <= !rd_data.two;
      end
    end
  end

  `BCHC_ASSERT_IMPL(a_pop_not_empty, pop, !q_empty)
  `BCHC_ASSERT_NEXT(a_second_follows, ov && sec && out_ch.ready, ov && last_q)
  `BCHC_ASSERT_IMPL(a_first_not_last, ov && sec, !last_q)
endmodule

### hdl/button_click_hold_classifier.sv
// Top level of the button click and hold classifier.
//
// Usage: in_ch carries one polling pass per item (timestamp in ms, pin level,
// press/release edges since the previous pass). out_ch carries the button
// events: hold buckets 1..4, single to quad click, with a final flag, the
// button id and a last marker on the final event of a pass.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// do so while the block is idle, unchecked; the write lands at a clock edge.
// Throughput: one pass per cycle while the queue is not full. The machine
// state updates in the accept cycle, so the next pass is taken at once. A
// pass yielding two events holds the output for both; the queue absorbs this.
// Path: an accepted pass's record is written into the queue, then its first
// event is loaded into the output register, which drives out_ch.
// Stall: when the receiver holds ready low the output register holds its
// event, the queue fills with FIFO_DEPTH pass records, then in_ch.ready drops.
// Reset (rst, synchronous): the machine returns to idle with flags, times and
// the click count cleared, the queue empties, config registers take defaults.
module button_click_hold_classifier #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  bchc_in_if.sink     in_ch,
  bchc_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);
  bchc_pkg::cfg_t cfg;
  bchc_pkg::rec_t wr_rec;
  bchc_pkg::rec_t rd_rec;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  // Configuration registers; take a write whenever the enable is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms        <= 16'd50;
      cfg.repeat_interval_ms <= 16'd1000;
      cfg.gap_timeout_ms     <= 16'd300;
      cfg.hold_tier1_ms      <= 24'd2000;
      cfg.hold_tier2_ms      <= 24'd5000;
      cfg.hold_tier3_ms      <= 24'd10000;
      cfg.hold_tier4_ms      <= 24'd20000;
      cfg.button_id          <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        bchc_pkg::REG_DEBOUNCE: cfg.debounce_ms        <= cfg_wdata[15:0];
        bchc_pkg::REG_REPEAT:   cfg.repeat_interval_ms <= cfg_wdata[15:0];
        bchc_pkg::REG_GAP:      cfg.gap_timeout_ms     <= cfg_wdata[15:0];
        bchc_pkg::REG_TIER1:    cfg.hold_tier1_ms      <= cfg_wdata;
        bchc_pkg::REG_TIER2:    cfg.hold_tier2_ms      <= cfg_wdata;
        bchc_pkg::REG_TIER3:    cfg.hold_tier3_ms      <= cfg_wdata;
        bchc_pkg::REG_TIER4:    cfg.hold_tier4_ms      <= cfg_wdata;
        bchc_pkg::REG_BUTTON:   cfg.button_id          <= cfg_wdata[3:0];
        default:                cfg <= cfg;
      endcase
    end
  end

  // Classify each pass and queue the event record it yields.
  bchc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .push   (push),
    .rec    (wr_rec)
  );

  // Decouple classification from the receiver's stalls.
  bchc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_rec),
    .pop     (pop),
    .rd_data (rd_rec),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Send one or two events per record, marking the last one.
  bchc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .rd_data (rd_rec),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );
endmodule
